FILE: rtl/twn_pkg.sv
// Shared types, constants and round functions of the TWINE-style cipher core.
package twn_pkg;

    localparam int ROUND_COUNT = 36;
    localparam int RC_W        = $clog2(ROUND_COUNT);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE = 2'd2;

    // Key size codes
    localparam logic KEY_80  = 1'b0;
    localparam logic KEY_128 = 1'b1;

    // Request codes
    localparam logic REQ_ENC = 1'b0;
    localparam logic REQ_DEC = 1'b1;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] RCON_POLY = 8'h1B;

    // Nibble 0 is the top nibble of the block, byte 0 the top byte of the key
    typedef logic [0:15][3:0] nib_arr_t;
    typedef logic [0:15][7:0] byte_arr_t;
    typedef logic [0:7][3:0]  rk_nib_t;
    typedef logic [31:0]      rkey_t;

    typedef struct packed {
        logic is_first;
        logic is_last;
    } cell_ctl_t;

    typedef struct packed {
        logic busy;
    } ks_stat_t;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h0, 4'hF, 4'hA, 4'h2, 4'hB, 4'h9, 4'h5,
        4'h8, 4'h3, 4'hD, 4'h7, 4'h1, 4'hE, 4'h6, 4'h4
    };

    // Destination of each nibble in the forward shuffle
    localparam logic [3:0] PERM_FWD [16] = '{
        4'd5, 4'd0, 4'd1, 4'd4, 4'd7, 4'd12, 4'd3, 4'd8,
        4'd13, 4'd6, 4'd9, 4'd2, 4'd15, 4'd10, 4'd11, 4'd14
    };

    function automatic nib_arr_t feistel(input nib_arr_t x, input rkey_t rk);
        nib_arr_t y;
        rk_nib_t  kn;
        y  = x;
        kn = rk;
        for (int j = 0; j < 8; j++)
        begin
            y[2*j+1] = x[2*j+1] ^ SBOX[x[2*j] ^ kn[j]];
        end
        return y;
    endfunction

    function automatic nib_arr_t shuffle_fwd(input nib_arr_t x);
        nib_arr_t y;
        y = '0;
        for (int h = 0; h < 16; h++)
        begin
            y[PERM_FWD[h]] = x[h];
        end
        return y;
    endfunction

    function automatic nib_arr_t unshuffle(input nib_arr_t x);
        nib_arr_t y;
        for (int h = 0; h < 16; h++)
        begin
            y[h] = x[PERM_FWD[h]];
        end
        return y;
    endfunction

    // One step of the 80-bit schedule: mix into byte 0, then shift down
    function automatic byte_arr_t ks_step(input byte_arr_t w, input logic [7:0] con);
        byte_arr_t  y;
        logic [7:0] v;
        logic [7:0] t;
        v = w[1] ^ w[3] ^ w[4] ^ w[6] ^ w[13] ^ w[14] ^ con;
        t = {SBOX[v[7:4]], SBOX[v[3:0]]};
        y = w;
        y[0] = y[0] ^ t;
        for (int k = 0; k < 15; k++)
        begin
            y[k] = y[k+1];
        end
        y[15] = y[0];
        return y;
    endfunction

    function automatic logic [7:0] rcon_double(input logic [7:0] con);
        return {con[6:0], 1'b0} ^ (con[7] ? RCON_POLY : 8'h00);
    endfunction

endpackage

FILE: rtl/twn_cell.sv
// One round cell of the cipher chain: Feistel layer plus shuffle (unshuffle before it when decrypting), one stage.
module twn_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  twn_pkg::cell_ctl_t ctl,
    input  twn_pkg::rkey_t    rk_enc,
    input  twn_pkg::rkey_t    rk_dec,
    input  logic              up_valid,
    input  logic              up_mode,
    input  logic [63:0]       up_block,
    output logic              up_ready,
    output logic              dn_valid,
    output logic              dn_mode,
    output logic [63:0]       dn_block,
    input  logic              dn_ready
);
    import twn_pkg::*;

    logic        valid_reg;
    logic        mode_reg;
    logic [63:0] block_reg;
    logic [63:0] block_next;

    nib_arr_t x;
    nib_arr_t t;

    always_comb
    begin
        x = up_block;
        if (up_mode == REQ_ENC)
        begin
            t = feistel(x, rk_enc);
            block_next = ctl.is_last ? t : shuffle_fwd(t);
        end
        else
        begin
            t = ctl.is_first ? x : unshuffle(x);
            block_next = feistel(t, rk_dec);
        end
    end

    // Take a word whenever this stage is empty or its contents move on
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            mode_reg  <= up_mode;
            block_reg <= block_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_mode  = mode_reg;
    assign dn_block = block_reg;

endmodule

FILE: rtl/twn_key_sched.sv
// Round key expansion: four schedule steps per cycle into a line of round keys.
module twn_key_sched (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  logic [63:0]        key_high,
    input  logic [63:0]        key_low,
    input  logic               key_size,
    output twn_pkg::rkey_t     rk_line [twn_pkg::ROUND_COUNT],
    output twn_pkg::ks_stat_t  stat
);
    import twn_pkg::*;

    logic            busy_reg;
    logic            load_reg;
    logic [RC_W-1:0] cnt_reg;
    byte_arr_t       w_reg;
    byte_arr_t       w_next;
    logic [7:0]      con_reg;
    rkey_t           rk_new;
    rkey_t           rk_reg [ROUND_COUNT];
    byte_arr_t       key_bytes;
    byte_arr_t       w_init;

    always_comb
    begin
        key_bytes = {key_high, key_low};
        w_init    = key_bytes;
        // 80-bit mode sees bytes 10 to 15 as zero
        for (int i = 10; i < 16; i++)
        begin
            w_init[i] = 8'h00;
        end
        w_next = w_reg;
        for (int s = 0; s < 4; s++)
        begin
            w_next = ks_step(w_next, con_reg);
        end
        if (key_size == KEY_128)
        begin
            rk_new = {key_bytes[2], key_bytes[3], key_bytes[12], key_bytes[15]};
        end
        else
        begin
            rk_new = {w_next[1], w_next[3], w_next[4], w_next[5]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            load_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (restart)
        begin
            busy_reg <= 1'b1;
            load_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (load_reg)
        begin
            load_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == RC_W'(ROUND_COUNT - 1))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            w_reg   <= w_init;
            con_reg <= RCON_INIT;
        end
        else if (busy_reg)
        begin
            w_reg   <= w_next;
            con_reg <= rcon_double(con_reg);
            for (int i = 0; i < ROUND_COUNT - 1; i++)
            begin
                rk_reg[i] <= rk_reg[i+1];
            end
            rk_reg[ROUND_COUNT-1] <= rk_new;
        end
    end

    assign rk_line   = rk_reg;
    assign stat.busy = busy_reg;

endmodule

FILE: rtl/twine_block_cipher_enc_dec_core.sv
// Top level of the TWINE-style 64-bit block cipher core, encrypt and decrypt.
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  -------------------------
//  cfg      in   cfg_wr_en              cfg_addr, cfg_wdata
//  in       in   in_valid / in_stall    req_type, block_in
//  out      out  out_valid / out_stall  block_out
//
// One word enters per cycle while in_stall is low, and each of the ROUND_COUNT
// round cells holds one; a word passes through every cell before it leaves.
// After reset and after each configuration write the key expansion runs,
// one round key per cycle, with in_stall high.
// An output stall holds the last cell and the full cells queued behind it;
// the rest close up bubbles, so input is taken while any cell is empty.
module twine_block_cipher_enc_dec_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [twn_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [twn_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [63:0]                   block_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [63:0]                   block_out
);
    import twn_pkg::*;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        key_size_reg;

    rkey_t    rk_line [ROUND_COUNT];
    ks_stat_t ks_stat;

    // Chain links: entry k feeds cell k, entry ROUND_COUNT is the output
    logic        valid_c [ROUND_COUNT+1];
    logic        mode_c  [ROUND_COUNT+1];
    logic [63:0] block_c [ROUND_COUNT+1];
    logic        ready_c [ROUND_COUNT+1];

    // Configuration registers: decode the index, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            key_size_reg <= KEY_80;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_KEY_HIGH: key_high_reg <= cfg_wdata;
                CFG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                CFG_KEY_SIZE: key_size_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // Re-derive the round keys from the registers after any write
    twn_key_sched u_key_sched (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_wr_en),
        .key_high (key_high_reg),
        .key_low  (key_low_reg),
        .key_size (key_size_reg),
        .rk_line  (rk_line),
        .stat     (ks_stat)
    );

    // Hold the input while the round keys are not yet settled
    assign valid_c[0] = in_valid && !ks_stat.busy;
    assign mode_c[0]  = req_type;
    assign block_c[0] = block_in;
    assign in_stall   = ks_stat.busy || !ready_c[0];

    // Encryption walks the keys upwards through the chain, decryption downwards
    for (genvar k = 0; k < ROUND_COUNT; k++)
    begin : g_cell
        cell_ctl_t ctl;
        assign ctl.is_first = (k == 0);
        assign ctl.is_last  = (k == ROUND_COUNT - 1);

        twn_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .rk_enc   (rk_line[k]),
            .rk_dec   (rk_line[ROUND_COUNT-1-k]),
            .up_valid (valid_c[k]),
            .up_mode  (mode_c[k]),
            .up_block (block_c[k]),
            .up_ready (ready_c[k]),
            .dn_valid (valid_c[k+1]),
            .dn_mode  (mode_c[k+1]),
            .dn_block (block_c[k+1]),
            .dn_ready (ready_c[k+1])
        );
    end

    // The last cell is the output register
    assign ready_c[ROUND_COUNT] = !out_stall;
    assign out_valid            = valid_c[ROUND_COUNT];
    assign block_out            = block_c[ROUND_COUNT];

endmodule

FILE: tb/sv/twine_block_cipher_enc_dec_checker.sv
`timescale 1ns / 100ps
// Checker for the TWINE-style cipher core: tracks the key registers, predicts and compares words.
module twine_block_cipher_enc_dec_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [twn_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [twn_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           req_type,
    input  logic [63:0]                    block_in,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [63:0]                    block_out,
    output int                             blocks_pending,
    output int                             mismatch_count
);
    import twn_pkg::*;

    localparam bit [3:0] SUB4 [16] = '{
        4'hC, 4'h0, 4'hF, 4'hA, 4'h2, 4'hB, 4'h9, 4'h5,
        4'h8, 4'h3, 4'hD, 4'h7, 4'h1, 4'hE, 4'h6, 4'h4
    };
    localparam bit [3:0] NIB_DEST [16] = '{
        4'd5, 4'd0, 4'd1, 4'd4, 4'd7, 4'd12, 4'd3, 4'd8,
        4'd13, 4'd6, 4'd9, 4'd2, 4'd15, 4'd10, 4'd11, 4'd14
    };
    localparam bit [7:0] CON_START  = 8'h01;
    localparam bit [7:0] CON_REDUCE = 8'h1B;

    bit [63:0] key_hi;
    bit [63:0] key_lo;
    bit        key_wide;
    bit [31:0] round_key [ROUND_COUNT];
    bit [63:0] expected_blocks [$];
    int        errors;

    // Rebuild the round keys from the key registers
    function automatic void refresh_round_keys();
        bit [7:0] w [16];
        bit [7:0] v;
        bit [7:0] t;
        bit [7:0] con;
        for (int i = 0; i < 16; i++)
        begin
            if (i < 8)
                w[i] = key_hi[63 - 8*i -: 8];
            else
                w[i] = key_lo[127 - 8*i -: 8];
        end
        if (key_wide)
        begin
            for (int i = 0; i < ROUND_COUNT; i++)
                round_key[i] = {w[2], w[3], w[12], w[15]};
        end
        else
        begin
            // short key: upper six bytes count as zero
            for (int i = 10; i < 16; i++)
                w[i] = 8'h00;
            con = CON_START;
            for (int i = 0; i < ROUND_COUNT; i++)
            begin
                for (int s = 0; s < 4; s++)
                begin
                    v = w[1] ^ w[3] ^ w[4] ^ w[6] ^ w[13] ^ w[14] ^ con;
                    t = {SUB4[v[7:4]], SUB4[v[3:0]]};
                    w[0] = w[0] ^ t;
                    for (int k = 0; k < 15; k++)
                        w[k] = w[k+1];
                    w[15] = w[0];
                end
                round_key[i] = {w[1], w[3], w[4], w[5]};
                con = {con[6:0], 1'b0} ^ (con[7] ? CON_REDUCE : 8'h00);
            end
        end
    endfunction

    function automatic bit [63:0] feistel_layer(bit [63:0] s, bit [31:0] rk);
        bit [3:0] e;
        for (int j = 0; j < 8; j++)
        begin
            e = s[63 - 8*j -: 4] ^ rk[31 - 4*j -: 4];
            s[59 - 8*j -: 4] = s[59 - 8*j -: 4] ^ SUB4[e];
        end
        return s;
    endfunction

    function automatic bit [63:0] shuffle_nibbles(bit [63:0] s, bit inverse);
        bit [63:0] y;
        for (int h = 0; h < 16; h++)
        begin
            if (inverse)
                y[63 - 4*h -: 4] = s[63 - 4*int'(NIB_DEST[h]) -: 4];
            else
                y[63 - 4*int'(NIB_DEST[h]) -: 4] = s[63 - 4*h -: 4];
        end
        return y;
    endfunction

    function automatic bit [63:0] twine_crypt(bit decrypt, bit [63:0] blk);
        bit [63:0] s;
        s = blk;
        if (!decrypt)
        begin
            for (int r = 0; r < ROUND_COUNT - 1; r++)
                s = shuffle_nibbles(feistel_layer(s, round_key[r]), 1'b0);
            s = feistel_layer(s, round_key[ROUND_COUNT-1]);
        end
        else
        begin
            s = feistel_layer(s, round_key[ROUND_COUNT-1]);
            for (int r = ROUND_COUNT - 2; r >= 0; r--)
                s = feistel_layer(shuffle_nibbles(s, 1'b1), round_key[r]);
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi   = '0;
            key_lo   = '0;
            key_wide = 1'b0;
            refresh_round_keys();
            expected_blocks.delete();
            blocks_pending <= 0;
            mismatch_count <= errors;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_KEY_HIGH: key_hi   = cfg_wdata;
                    CFG_KEY_LOW:  key_lo   = cfg_wdata;
                    CFG_KEY_SIZE: key_wide = cfg_wdata[0];
                    default: ;
                endcase
                refresh_round_keys();
            end
            if (in_valid && !in_stall)
                expected_blocks.push_back(twine_crypt(req_type == REQ_DEC, block_in));
            if (out_valid && !out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, block_out);
                end
                else if (block_out !== expected_blocks[0])
                begin
                    errors++;
                    $display("%0t: block_out mismatch, expected %h, actual %h",
                             $time, expected_blocks[0], block_out);
                    void'(expected_blocks.pop_front());
                end
                else
                    void'(expected_blocks.pop_front());
            end
            blocks_pending <= expected_blocks.size();
            mismatch_count <= errors;
        end
    end

endmodule

FILE: tb/sv/twine_block_cipher_enc_dec_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the TWINE-style cipher core: stimulus, back-pressure and verdict.
module twine_block_cipher_enc_dec_core_tb;
    import twn_pkg::*;

    // Index past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr   = CFG_KEY_HIGH;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic                  req_type   = REQ_ENC;
    logic [63:0]           block_in   = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [63:0]           block_out;

    int blocks_pending;
    int mismatch_count;

    // Idle percentages of the sender and of the receiver
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    twine_block_cipher_enc_dec_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .block_in  (block_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .block_out (block_out)
    );

    twine_block_cipher_enc_dec_checker crypt_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .block_in       (block_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .block_out      (block_out),
        .blocks_pending (blocks_pending),
        .mismatch_count (mismatch_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver back-pressure: raise the stall at random, one decision per edge
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Offer one word and hold it until it is taken. Idle cycles go before the
    // word, so the valid only drops between words and a held word never moves.
    // Handshake signals are read straight after the edge, i.e. before the
    // nonblocking updates of that edge land.
    task automatic send_block(input logic req, input logic [63:0] blk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        block_in <= blk;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Load all key registers, plus a stray write to the unused index. The
    // spare bits of the key-size word carry noise, which must be ignored.
    // The core then runs its key expansion with in_stall high; the next
    // send simply waits for it.
    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo, input logic wide);
        logic [63:0] size_word;
        size_word    = {$urandom, $urandom};
        size_word[0] = wide;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_KEY_HIGH;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_addr  <= CFG_KEY_LOW;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_addr  <= CFG_KEY_SIZE;
        cfg_wdata <= size_word;
        @(posedge clk);
        cfg_addr  <= CFG_UNUSED;
        cfg_wdata <= {$urandom, $urandom};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Drop the valid and hold until every expected word has come back. The
    // pending count is registered in the checker, so always advance at least once.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (blocks_pending != 0);
    endtask

    task automatic send_both_ways(input logic [63:0] blk);
        send_block(REQ_ENC, blk);
        send_block(REQ_DEC, blk);
    endtask

    initial
    begin
        logic [63:0] pattern [6];
        pattern = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};

        // Hold reset, then release it on an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the first idling mix
        tx_idle_pct = 36;
        rx_idle_pct = 79;

        // Reset key: all zero, short key size
        send_both_ways(pattern[0]);

        // Short key with every register bit set: the upper key bytes must not count
        wait_idle();
        write_key('1, '1, KEY_80);
        foreach (pattern[p])
            send_both_ways(pattern[p]);

        // Long key, both extremes
        wait_idle();
        write_key('0, '0, KEY_128);
        send_both_ways(pattern[0]);
        send_both_ways(pattern[1]);
        wait_idle();
        write_key('1, '1, KEY_128);
        send_both_ways(pattern[0]);
        send_both_ways(pattern[5]);

        // Random part: six segments, each with a fresh random key, alternating
        // key size. Two segments per idling mix: sender light and receiver
        // heavy, then the reverse, then full rate on both sides.
        for (int seg = 0; seg < 6; seg++)
        begin
            wait_idle();
            case (seg / 2)
                0:
                begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 79;
                end
                1:
                begin
                    tx_idle_pct = 79;
                    rx_idle_pct = 36;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_key({$urandom, $urandom}, {$urandom, $urandom},
                      seg[0] ? KEY_128 : KEY_80);
            repeat (283)
                send_block($urandom_range(0, 1) ? REQ_DEC : REQ_ENC, {$urandom, $urandom});
        end

        // Drain, then allow a pipeline's worth of cycles for any stray word
        wait_idle();
        repeat (ROUND_COUNT + 8) @(posedge clk);

        if (mismatch_count == 0 && blocks_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
